/* hw/rtl/btmx_pkg.sv */
// Types, constants and codes shared by the binary trie max-xor unit.
package btmx_pkg;

  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned POOL_NODES  = 1 + MAX_ENTRIES * KEY_BITS;
  localparam int unsigned NODE_W      = $clog2(POOL_NODES);
  localparam int unsigned LEVEL_W     = $clog2(KEY_BITS);
  localparam int unsigned COUNT_W     = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned HELD_W   = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [1:0][NODE_W-1:0] links_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    max_xor;
    logic [STATUS_W-1:0] status;
    logic [HELD_W-1:0]   entries_held;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic alloc;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic walk_ok;
    logic missing;
    logic last_level;
    logic leaf;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_ALLOC = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

/* hw/rtl/btmx_ctrl.sv */
// Sequencer for the trie walk: accept, walk levels, allocate nodes, deliver result.
module btmx_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  btmx_pkg::sts_t   sts_i,
  output btmx_pkg::ctl_t   ctl_o
);

  btmx_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      btmx_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = btmx_pkg::S_WALK;
        end
      end
      btmx_pkg::S_WALK: begin
        if (!sts_i.walk_ok) begin
          state_d = btmx_pkg::S_DONE;
        end else begin
          ctl_o.walk = 1'b1;
          if (sts_i.missing) begin
            state_d = btmx_pkg::S_ALLOC;
          end else if (sts_i.last_level) begin
            state_d = btmx_pkg::S_DONE;
          end
        end
      end
      btmx_pkg::S_ALLOC: begin
        ctl_o.alloc = 1'b1;
        if (sts_i.leaf) begin
          state_d = btmx_pkg::S_DONE;
        end
      end
      btmx_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.commit = 1'b1;
          state_d      = btmx_pkg::S_IDLE;
        end
      end
      default: state_d = btmx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btmx_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != btmx_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == btmx_pkg::S_DONE))
    else $error("result valid raised outside commit");

  a_alloc_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btmx_pkg::S_ALLOC) |->
      $past(state_q == btmx_pkg::S_WALK || state_q == btmx_pkg::S_ALLOC))
    else $error("allocation entered without a walk");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit overwrote a stalled result");

endmodule

/* hw/rtl/btmx_dp.sv */
// Datapath: node memory, root links, walk registers, allocator and result register.
module btmx_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btmx_pkg::in_item_t  in_item_i,
  output btmx_pkg::out_item_t out_item_o,
  input  btmx_pkg::ctl_t      ctl_i,
  output btmx_pkg::sts_t      sts_o
);

  btmx_pkg::links_t node_mem_q [btmx_pkg::POOL_NODES];

  logic [btmx_pkg::CMD_W-1:0]    cmd_q;
  logic [btmx_pkg::KEY_BITS-1:0] key_q;
  logic [btmx_pkg::KEY_BITS-1:0] best_q;
  logic [btmx_pkg::LEVEL_W-1:0]  level_q;
  logic                          leaf_q;
  btmx_pkg::node_t               cur_node_q;
  btmx_pkg::node_t               nf_q;
  logic [btmx_pkg::COUNT_W-1:0]  count_q;
  btmx_pkg::links_t              root_q;
  btmx_pkg::links_t              rd_q;
  btmx_pkg::out_item_t           out_q;

  btmx_pkg::links_t cur_links, new_links;
  btmx_pkg::node_t  same_child, other_child, next_node;
  logic             key_bit, is_insert, is_query, full, empty, take_other;
  logic             mem_we, root_we;
  btmx_pkg::out_item_t out_d;

  assign cur_links   = (cur_node_q == '0) ? root_q : rd_q;
  assign key_bit     = key_q[level_q];
  assign same_child  = cur_links[key_bit];
  assign other_child = cur_links[~key_bit];
  assign is_insert   = (cmd_q == btmx_pkg::CMD_INSERT);
  assign is_query    = (cmd_q == btmx_pkg::CMD_QUERY);
  assign full        = (count_q >= btmx_pkg::COUNT_W'(btmx_pkg::MAX_ENTRIES));
  assign empty       = (count_q == '0);
  assign take_other  = is_query && (other_child != '0);
  assign next_node   = take_other ? other_child : same_child;

  assign sts_o.walk_ok    = (is_insert && !full) || (is_query && !empty);
  assign sts_o.missing    = is_insert && (same_child == '0);
  assign sts_o.last_level = (level_q == '0);
  assign sts_o.leaf       = leaf_q;

  always_comb begin
    new_links = '0;
    mem_we    = 1'b0;
    root_we   = 1'b0;
    if (ctl_i.walk && sts_o.missing) begin
      new_links          = cur_links;
      new_links[key_bit] = nf_q;
      root_we            = (cur_node_q == '0);
      mem_we             = (cur_node_q != '0);
    end else if (ctl_i.alloc) begin
      if (!leaf_q) begin
        new_links[key_bit] = nf_q;
      end
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[cur_node_q] <= new_links;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= node_mem_q[next_node];
  end

  always_comb begin
    out_d.max_xor      = (is_query && !empty) ? btmx_pkg::KEY_W'(best_q) : '0;
    out_d.status       = btmx_pkg::ST_DONE;
    out_d.entries_held = btmx_pkg::HELD_W'(count_q);
    case (cmd_q)
      btmx_pkg::CMD_INSERT: begin
        if (full) begin
          out_d.status = btmx_pkg::ST_FULL;
        end else begin
          out_d.entries_held = btmx_pkg::HELD_W'(count_q + 1'b1);
        end
      end
      btmx_pkg::CMD_QUERY: begin
        if (empty) begin
          out_d.status = btmx_pkg::ST_EMPTY;
        end
      end
      btmx_pkg::CMD_CLEAR: begin
        out_d.entries_held = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q      <= in_item_i.command;
      key_q      <= in_item_i.key[btmx_pkg::KEY_BITS-1:0];
      level_q    <= btmx_pkg::LEVEL_W'(btmx_pkg::KEY_BITS - 1);
      cur_node_q <= '0;
      best_q     <= '0;
      leaf_q     <= 1'b0;
    end else if (ctl_i.walk || (ctl_i.alloc && !leaf_q)) begin
      if (ctl_i.walk && !sts_o.missing) begin
        cur_node_q <= next_node;
        if (take_other) begin
          best_q[level_q] <= 1'b1;
        end
      end else begin
        cur_node_q <= nf_q;
      end
      if (level_q == '0) begin
        leaf_q <= 1'b1;
      end else begin
        level_q <= level_q - 1'b1;
      end
    end
    if (ctl_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q    <= btmx_pkg::NODE_W'(1);
      count_q <= '0;
      root_q  <= '0;
    end else begin
      if (root_we) begin
        root_q <= new_links;
      end
      if ((ctl_i.walk && sts_o.missing) || (ctl_i.alloc && !leaf_q)) begin
        nf_q <= nf_q + 1'b1;
      end
      if (ctl_i.commit) begin
        if (cmd_q == btmx_pkg::CMD_CLEAR) begin
          nf_q    <= btmx_pkg::NODE_W'(1);
          count_q <= '0;
          root_q  <= '0;
        end else if (is_insert && !full) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  assign out_item_o = out_q;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nf_q <= btmx_pkg::NODE_W'(btmx_pkg::POOL_NODES)))
    else $error("node pool overrun");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= btmx_pkg::COUNT_W'(btmx_pkg::MAX_ENTRIES)))
    else $error("entry count above limit");

  a_alloc_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc |-> (cur_node_q != '0) && is_insert)
    else $error("allocation aimed at root or outside insert");

endmodule

/* hw/rtl/binary_trie_max_xor_unit.sv */
// Top level of the binary trie max-xor unit: sequencer plus datapath.
// A query or an insert walks the trie one level at a time, from the top key bit down; an insert that
// meets a missing child goes on to allocate nodes. Clear, refused and empty commands skip the walk.
// The unit takes no new item until the last is committed; each level costs one node memory read.
// A finished result sits in an output register; the next item is taken while it waits.
// Reset empties the trie (root links, free pointer, count) at once; no clearing pass.
module binary_trie_max_xor_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  btmx_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output btmx_pkg::out_item_t out_item_o
);

  btmx_pkg::ctl_t ctl;
  btmx_pkg::sts_t sts;

  btmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  btmx_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .ctl_i      (ctl),
    .sts_o      (sts)
  );

endmodule

/* sim/trie_xor_checker.sv */
// Checker for the binary trie max-xor unit: predicts each result and compares it.
`timescale 1ns / 100ps

module trie_xor_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  btmx_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  btmx_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [btmx_pkg::KEY_W-1:0] KEY_MASK =
    btmx_pkg::KEY_W'((64'd1 << btmx_pkg::KEY_BITS) - 64'd1);

  logic [btmx_pkg::NODE_W-1:0] trie_child [btmx_pkg::POOL_NODES][2];
  int unsigned                 free_node;
  int unsigned                 held_count;
  btmx_pkg::out_item_t         awaited_results[$];
  int                          fail_count = 0;

  function automatic void trie_empty();
    trie_child[0][0] = '0;
    trie_child[0][1] = '0;
    free_node  = 1;
    held_count = 0;
  endfunction

  function automatic void trie_insert(logic [btmx_pkg::KEY_W-1:0] k);
    int unsigned node;
    int unsigned child;
    node = 0;
    for (int lv = btmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
      child = trie_child[node][k[lv]];
      if (child == 0) begin
        child = free_node;
        free_node++;
        trie_child[child][0] = '0;
        trie_child[child][1] = '0;
        trie_child[node][k[lv]] = btmx_pkg::NODE_W'(child);
      end
      node = child;
    end
  endfunction

  function automatic logic [btmx_pkg::KEY_W-1:0] trie_best_xor(
    logic [btmx_pkg::KEY_W-1:0] k
  );
    int unsigned                 node;
    logic [btmx_pkg::NODE_W-1:0] other;
    logic [btmx_pkg::KEY_W-1:0]  best;
    node = 0;
    best = '0;
    for (int lv = btmx_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
      other = trie_child[node][!k[lv]];
      if (other != 0) begin
        best[lv] = 1'b1;
        node     = other;
      end else begin
        node = trie_child[node][k[lv]];
      end
    end
    return best;
  endfunction

  function automatic btmx_pkg::out_item_t predict_trie_result(btmx_pkg::in_item_t item);
    btmx_pkg::out_item_t        res;
    logic [btmx_pkg::KEY_W-1:0] k;
    res = '0;
    k   = item.key & KEY_MASK;
    case (item.command)
      btmx_pkg::CMD_INSERT: begin
        if (held_count >= btmx_pkg::MAX_ENTRIES) begin
          res.status = btmx_pkg::ST_FULL;
        end else begin
          trie_insert(k);
          held_count++;
        end
      end
      btmx_pkg::CMD_QUERY: begin
        if (held_count == 0) res.status = btmx_pkg::ST_EMPTY;
        else res.max_xor = trie_best_xor(k);
      end
      btmx_pkg::CMD_CLEAR: trie_empty();
      default: ;
    endcase
    res.entries_held = btmx_pkg::HELD_W'(held_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    btmx_pkg::out_item_t want;
    if (!rst_ni) begin
      trie_empty();
      awaited_results.delete();
      fail_count_o <= fail_count;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no command outstanding: %p", out_item_i);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item_i.max_xor !== want.max_xor) begin
            $error("max_xor: expected %h, actual %h", want.max_xor, out_item_i.max_xor);
            fail_count++;
          end
          if (out_item_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item_i.status);
            fail_count++;
          end
          if (out_item_i.entries_held !== want.entries_held) begin
            $error("entries_held: expected %0d, actual %0d",
                   want.entries_held, out_item_i.entries_held);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.insert(awaited_results.size(), predict_trie_result(in_item_i));
      end
      fail_count_o <= fail_count;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the binary trie max-xor unit: clock, reset, commands, stalls, verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [btmx_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TOTAL     = 650;
  localparam int QUIET_ITEMS    = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  btmx_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  btmx_pkg::out_item_t out_item_o;

  int          fail_count;
  int          pending;
  int          sent_count = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          quiet_phase = 1'b0;
  logic [31:0] prefix_base = '0;

  binary_trie_max_xor_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  trie_xor_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (quiet_phase) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      1:       return 32'h1 << $urandom_range(0, 31);
      2, 3, 4: return prefix_base ^ ($urandom >> $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_command(logic [btmx_pkg::CMD_W-1:0] cmd,
                               logic [btmx_pkg::KEY_W-1:0] key);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_item_i  <= '{command: cmd, key: key};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent_count++;
    if (sent_count >= ITEM_TOTAL - QUIET_ITEMS) quiet_phase <= 1'b1;
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int fill_target;
    int inserted;
    int roll;
    int session_idx;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_command(btmx_pkg::CMD_QUERY,  32'h0000_0000);
    issue_command(CMD_UNUSED,           32'hFFFF_FFFF);
    issue_command(btmx_pkg::CMD_INSERT, 32'h0000_0000);
    issue_command(btmx_pkg::CMD_QUERY,  32'h0000_0000);
    issue_command(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
    issue_command(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    issue_command(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    issue_command(btmx_pkg::CMD_QUERY,  32'h0000_0000);
    issue_command(btmx_pkg::CMD_QUERY,  32'h8000_0000);
    issue_command(btmx_pkg::CMD_INSERT, 32'h5555_5555);
    issue_command(btmx_pkg::CMD_QUERY,  32'hAAAA_AAAA);
    issue_command(btmx_pkg::CMD_QUERY,  32'h0000_0001);
    issue_command(CMD_UNUSED,           32'h1234_5678);
    issue_command(btmx_pkg::CMD_CLEAR,  32'hFFFF_FFFF);
    issue_command(btmx_pkg::CMD_QUERY,  32'h5555_5555);
    issue_command(btmx_pkg::CMD_INSERT, 32'h8000_0000);
    issue_command(btmx_pkg::CMD_QUERY,  32'h7FFF_FFFF);
    issue_command(btmx_pkg::CMD_CLEAR,  32'h0000_0000);
    issue_command(btmx_pkg::CMD_CLEAR,  32'hAAAA_AAAA);
    wait_drained();

    session_idx = 0;
    while (sent_count < ITEM_TOTAL) begin
      issue_command(btmx_pkg::CMD_CLEAR, $urandom);
      prefix_base = $urandom;
      if (session_idx == 1 || $urandom_range(0, 5) == 0) fill_target = $urandom_range(126, 134);
      else fill_target = $urandom_range(1, 24);
      if ($urandom_range(0, 2) == 0) issue_command(btmx_pkg::CMD_QUERY, pick_key());
      inserted = 0;
      while (inserted < fill_target && sent_count < ITEM_TOTAL) begin
        roll = $urandom_range(0, 15);
        if (roll < 9) begin
          issue_command(btmx_pkg::CMD_INSERT, pick_key());
          inserted++;
        end else if (roll < 15) begin
          issue_command(btmx_pkg::CMD_QUERY, pick_key());
        end else begin
          issue_command(CMD_UNUSED, $urandom);
        end
      end
      repeat ($urandom_range(1, 6)) issue_command(btmx_pkg::CMD_QUERY, pick_key());
      if ($urandom_range(0, 2) == 0) wait_drained();
      session_idx++;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* binary_trie_max_xor_unit.f */
hw/rtl/btmx_pkg.sv
hw/rtl/btmx_ctrl.sv
hw/rtl/btmx_dp.sv
hw/rtl/binary_trie_max_xor_unit.sv
sim/trie_xor_checker.sv
sim/tb_top.sv
